/* hdl/aod_pkg.sv */
// shared types, constants and helpers for the accelerometer orientation detector
package aod_pkg;

  localparam int WINDOW     = 50;
  localparam int POS_W      = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int SMP_W      = 16;
  localparam int MAG_W      = SMP_W + 1;
  localparam int LOCK_W     = 21;
  localparam int SUM_W      = $clog2(WINDOW * (1 << (SMP_W - 1)) + 1);
  localparam int CMP_W      = (SUM_W > LOCK_W) ? SUM_W : LOCK_W;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = LOCK_W;
  localparam int IN_DATA_W  = 3 * SMP_W;
  localparam int OUT_DATA_W = 8;

  localparam logic [CFG_IDX_W-1:0] REG_GRAVITY_LOW     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GRAVITY_HIGH    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LOCK_DIFFERENCE = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ACCIDENT_HIGH   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ACCIDENT_LOW    = 3'd4;

  localparam logic signed [SMP_W-1:0] GRAVITY_LOW_RST     = 16'sd2135;
  localparam logic signed [SMP_W-1:0] GRAVITY_HIGH_RST    = 16'sd2888;
  localparam logic [LOCK_W-1:0]       LOCK_DIFFERENCE_RST = 21'd7680;
  localparam logic signed [SMP_W-1:0] ACCIDENT_HIGH_RST   = 16'sd5120;
  localparam logic signed [SMP_W-1:0] ACCIDENT_LOW_RST    = 16'sd0;

  typedef enum logic [1:0] {
    AX_X    = 2'd0,
    AX_Y    = 2'd1,
    AX_Z    = 2'd2,
    AX_NONE = 2'd3
  } axis_t;

  typedef logic signed [SMP_W-1:0] smp_t;

  typedef struct packed {
    smp_t x;
    smp_t y;
    smp_t z;
  } sample_t;

  typedef struct packed {
    logic [SUM_W-1:0] x;
    logic [SUM_W-1:0] y;
    logic [SUM_W-1:0] z;
  } sums_t;

  typedef struct packed {
    smp_t              gravity_low;
    smp_t              gravity_high;
    logic [LOCK_W-1:0] lock_difference;
    smp_t              accident_high;
    smp_t              accident_low;
  } cfg_t;

  typedef struct packed {
    logic  accident;
    axis_t up_axis;
    axis_t side_axis;
    axis_t forward_axis;
    logic  locked;
  } result_t;

  // magnitude of a sample, the most negative value gives 32768
  function automatic logic [MAG_W-1:0] mag16(smp_t v);
    logic [MAG_W-1:0] e;
    e = {v[SMP_W-1], v};
    return v[SMP_W-1] ? (~e + 1'b1) : e;
  endfunction

endpackage

/* hdl/accel_axis_orientation_detector_top.sv */
// top level: config registers, input and result registers around the detector logic
// an accepted item goes to the input register, then its result to the result register
// one item per cycle when the result is taken or absent, set by ring read and sum update
// the result register frees the input side whenever the result is taken or absent
// reset: synchronous active low, restores config defaults, clears sums and lock state
// the sample ring needs no clearing pass: slots read as zero until the first wrap
module accel_axis_orientation_detector_top (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [aod_pkg::IN_DATA_W-1:0]    in_tdata,   // accel_x, accel_y, accel_z
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [aod_pkg::OUT_DATA_W-1:0]   out_tdata,  // locked, forward_axis, side_axis,
                                                       // up_axis, accident
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [aod_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [aod_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import aod_pkg::*;

  cfg_t    cfg_r;
  sample_t smp_r;
  logic    smp_valid_r;
  result_t out_res_r;
  logic    out_valid_r;
  logic    advance;
  logic    process;
  sums_t   sums_nxt;
  result_t res;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.gravity_low     <= GRAVITY_LOW_RST;
      cfg_r.gravity_high    <= GRAVITY_HIGH_RST;
      cfg_r.lock_difference <= LOCK_DIFFERENCE_RST;
      cfg_r.accident_high   <= ACCIDENT_HIGH_RST;
      cfg_r.accident_low    <= ACCIDENT_LOW_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_GRAVITY_LOW:     cfg_r.gravity_low     <= cfg_data[SMP_W-1:0];
        REG_GRAVITY_HIGH:    cfg_r.gravity_high    <= cfg_data[SMP_W-1:0];
        REG_LOCK_DIFFERENCE: cfg_r.lock_difference <= cfg_data[LOCK_W-1:0];
        REG_ACCIDENT_HIGH:   cfg_r.accident_high   <= cfg_data[SMP_W-1:0];
        REG_ACCIDENT_LOW:    cfg_r.accident_low    <= cfg_data[SMP_W-1:0];
        default: ;
      endcase
    end
  end

  // the stage moves when the result register is empty or being emptied
  assign advance   = !out_valid_r || out_tready;
  assign process   = smp_valid_r && advance;
  assign in_tready = !smp_valid_r || advance;

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      smp_r.x <= in_tdata[SMP_W-1:0];
      smp_r.y <= in_tdata[2*SMP_W-1:SMP_W];
      smp_r.z <= in_tdata[3*SMP_W-1:2*SMP_W];
    end
    if (process) begin
      out_res_r <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      smp_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_tready) begin
        smp_valid_r <= in_tvalid;
      end
      if (advance) begin
        out_valid_r <= smp_valid_r;
      end
    end
  end

  aod_window u_window (
    .clk      (clk),
    .rst_n    (rst_n),
    .upd      (process),
    .smp      (smp_r),
    .sums_nxt (sums_nxt)
  );

  aod_lock u_lock (
    .clk   (clk),
    .rst_n (rst_n),
    .upd   (process),
    .smp   (smp_r),
    .cfg   (cfg_r),
    .sums  (sums_nxt),
    .res   (res)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_res_r.accident, out_res_r.up_axis, out_res_r.side_axis,
                       out_res_r.forward_axis, out_res_r.locked};

  a_accident_needs_lock: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !out_res_r.accident || out_res_r.locked)
    else $error("accident flagged while unlocked");

  a_no_stall_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid_r |-> in_tready)
    else $error("input stalled with an empty result register");

endmodule

/* hdl/aod_window.sv */
// sample ring of magnitudes and running per-axis absolute sums over the window
module aod_window (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           upd,
  input  aod_pkg::sample_t smp,
  output aod_pkg::sums_t sums_nxt
);
  import aod_pkg::*;

  logic [3*MAG_W-1:0] ring_mem [WINDOW];
  logic [3*MAG_W-1:0] rd_q_r;
  logic [POS_W-1:0]   pos_r, pos_nxt, rd_addr;
  logic               wrapped_r;
  sums_t              sums_r;
  logic [MAG_W-1:0]   new_x, new_y, new_z;
  logic [MAG_W-1:0]   old_x, old_y, old_z;
  logic               last_slot;

  assign new_x = mag16(smp.x);
  assign new_y = mag16(smp.y);
  assign new_z = mag16(smp.z);

  // slots not yet written since reset read as zero
  assign {old_x, old_y, old_z} = wrapped_r ? rd_q_r : '0;

  assign last_slot = (pos_r == POS_W'(WINDOW - 1));
  assign pos_nxt   = last_slot ? '0 : pos_r + 1'b1;
  // prefetch the slot that the next item overwrites
  assign rd_addr   = upd ? pos_nxt : pos_r;

  assign sums_nxt.x = sums_r.x - SUM_W'(old_x) + SUM_W'(new_x);
  assign sums_nxt.y = sums_r.y - SUM_W'(old_y) + SUM_W'(new_y);
  assign sums_nxt.z = sums_r.z - SUM_W'(old_z) + SUM_W'(new_z);

  always_ff @(posedge clk) begin
    if (upd) begin
      ring_mem[pos_r] <= {new_x, new_y, new_z};
    end
    rd_q_r <= ring_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r     <= '0;
      wrapped_r <= 1'b0;
      sums_r    <= '0;
    end else if (upd) begin
      pos_r  <= pos_nxt;
      sums_r <= sums_nxt;
      if (last_slot) begin
        wrapped_r <= 1'b1;
      end
    end
  end

  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r <= POS_W'(WINDOW - 1))
    else $error("ring position beyond window");

  a_sums_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !upd |=> $stable(sums_r) && $stable(pos_r))
    else $error("window sums moved without an item");

endmodule

/* hdl/aod_lock.sv */
// gravity band check, axis lock decision and accident flag
module aod_lock (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              upd,
  input  aod_pkg::sample_t  smp,
  input  aod_pkg::cfg_t     cfg,
  input  aod_pkg::sums_t    sums,
  output aod_pkg::result_t  res
);
  import aod_pkg::*;

  logic             locked_r, locked_nxt;
  axis_t            fwd_r, fwd_nxt;
  axis_t            side_r, side_nxt;
  axis_t            up_r, up_nxt;
  logic             band_x, band_y, band_z;
  logic             hit;
  axis_t            up_cand, a_ax, b_ax;
  logic [SUM_W-1:0] sa, sb;
  logic             a_gt;
  logic [SUM_W-1:0] diff;
  logic             enough;

  function automatic logic [SUM_W-1:0] pick_sum(sums_t s, axis_t ax);
    logic [SUM_W-1:0] v;
    unique case (ax)
      AX_X:    v = s.x;
      AX_Y:    v = s.y;
      AX_Z:    v = s.z;
      default: v = '0;
    endcase
    return v;
  endfunction

  assign band_x = (smp.x >= cfg.gravity_low) && (smp.x <= cfg.gravity_high);
  assign band_y = (smp.y >= cfg.gravity_low) && (smp.y <= cfg.gravity_high);
  assign band_z = (smp.z >= cfg.gravity_low) && (smp.z <= cfg.gravity_high);

  // y wins over x, x over z
  always_comb begin
    if (band_y) begin
      hit = 1'b1; up_cand = AX_Y; a_ax = AX_Z; b_ax = AX_X;
    end else if (band_x) begin
      hit = 1'b1; up_cand = AX_X; a_ax = AX_Z; b_ax = AX_Y;
    end else if (band_z) begin
      hit = 1'b1; up_cand = AX_Z; a_ax = AX_X; b_ax = AX_Y;
    end else begin
      hit = 1'b0; up_cand = AX_NONE; a_ax = AX_Z; b_ax = AX_X;
    end
  end

  assign sa     = pick_sum(sums, a_ax);
  assign sb     = pick_sum(sums, b_ax);
  assign a_gt   = sa > sb;
  assign diff   = a_gt ? (sa - sb) : (sb - sa);
  assign enough = CMP_W'(diff) > CMP_W'(cfg.lock_difference);

  always_comb begin
    locked_nxt = locked_r;
    fwd_nxt    = fwd_r;
    side_nxt   = side_r;
    up_nxt     = up_r;
    if (!locked_r && hit) begin
      up_nxt = up_cand;
      if (enough) begin
        locked_nxt = 1'b1;
        fwd_nxt    = a_gt ? a_ax : b_ax;
        side_nxt   = a_gt ? b_ax : a_ax;
      end
    end
  end

  assign res.locked       = locked_nxt;
  assign res.forward_axis = fwd_nxt;
  assign res.side_axis    = side_nxt;
  assign res.up_axis      = up_nxt;
  assign res.accident     = locked_nxt &&
                            ((smp.x > cfg.accident_high) || (smp.x < cfg.accident_low));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      locked_r <= 1'b0;
      fwd_r    <= AX_NONE;
      side_r   <= AX_NONE;
      up_r     <= AX_NONE;
    end else if (upd) begin
      locked_r <= locked_nxt;
      fwd_r    <= fwd_nxt;
      side_r   <= side_nxt;
      up_r     <= up_nxt;
    end
  end

  a_lock_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    locked_r |=> locked_r && $stable(fwd_r) && $stable(side_r) && $stable(up_r))
    else $error("axis assignment changed after lock");

  a_lock_distinct: assert property (@(posedge clk) disable iff (!rst_n)
    locked_r |-> fwd_r != side_r && fwd_r != up_r && side_r != up_r &&
                 fwd_r != AX_NONE && side_r != AX_NONE && up_r != AX_NONE)
    else $error("locked axes not a permutation");

endmodule
